>>> rtl/signed_int_to_decimal_ascii_top_macros.svh
// Assertion macros used by the checker file of the decimal text converter.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_TOP_MACROS_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define SIDA_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SIDA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/sida_pkg.sv
// Package with the types and constants of the decimal text converter.
package sida_pkg;

   // Input field width and the number of bits that carry the value.
   localparam int IN_BITS    = 32;
   localparam int VALUE_BITS = 32;

   // Upper bound on decimal digits of the magnitude (1233/4096 approximates log10 of 2).
   localparam int DIGITS     = (VALUE_BITS * 1233) / 4096 + 1;
   localparam int BCD_BITS   = 4 * DIGITS;
   localparam int IDX_BITS   = (DIGITS > 1) ? $clog2(DIGITS) : 1;

   // Binary to BCD conversion handles this many magnitude bits per stage.
   localparam int STEP_BITS  = 8;
   localparam int DD_STAGES  = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
   localparam int PAD_BITS   = DD_STAGES * STEP_BITS;

   // Character codes.
   localparam int CHAR_BITS = 6;
   localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 6'd45;
   localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 6'd48;
   localparam logic [CHAR_BITS-1:0] CHAR_NINE  = 6'd57;

   typedef logic [DIGITS-1:0][3:0] sida_bcd_type;

   // Item inside the conversion pipeline.
   typedef struct packed {
      logic                neg;
      sida_bcd_type        bcd;
      logic [PAD_BITS-1:0] bin;
   } sida_work_type;

   // Converted item ready for character output.
   typedef struct packed {
      logic                neg;
      sida_bcd_type        bcd;
      logic [IDX_BITS-1:0] top_idx;
   } sida_text_type;

endpackage

>>> rtl/sida_dabble_stage.sv
// One pipeline stage of the shift-and-add-three binary to BCD conversion.
module sida_dabble_stage (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  sida_pkg::sida_work_type in_data,
   output logic                    in_stall,
   output logic                    out_valid,
   output sida_pkg::sida_work_type out_data,
   input  logic                    out_stall
);
   import sida_pkg::*;

   logic          valid_ff;
   logic          valid_in;
   logic          advance;
   sida_work_type data_ff;
   sida_work_type data_in;

   // The stage moves when it is empty or its item leaves downstream.
   assign advance   = !valid_ff || !out_stall;
   assign in_stall  = !advance;
   assign valid_in  = advance ? in_valid : valid_ff;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   // Shift STEP_BITS magnitude bits into the BCD digits, correcting before each shift.
   always_comb begin
      sida_bcd_type                  bcd;
      logic [PAD_BITS-1:0]           bin;
      logic [BCD_BITS+PAD_BITS-1:0]  cat;
      bcd = in_data.bcd;
      bin = in_data.bin;
      cat = '0;
      for (int s = 0; s < STEP_BITS; s++) begin
         for (int d = 0; d < DIGITS; d++) begin
            if (bcd[d] >= 4'd5) begin
               bcd[d] = bcd[d] + 4'd3;
            end
         end
         cat = {bcd, bin} << 1;
         bcd = cat[PAD_BITS +: BCD_BITS];
         bin = cat[PAD_BITS-1:0];
      end
      data_in.neg = in_data.neg;
      data_in.bcd = bcd;
      data_in.bin = bin;
   end

   // Valid bit.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload register.
   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

endmodule

>>> rtl/sida_serializer.sv
// Character sequencer that emits the sign and the significant digits of one item.
module sida_serializer (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   input  sida_pkg::sida_text_type             in_data,
   output logic                                in_stall,
   output logic                                rsp_valid,
   output logic [sida_pkg::CHAR_BITS-1:0]      rsp_text_char,
   input  logic                                rsp_stall,
   output logic                                rsp_last
);
   import sida_pkg::*;

   logic                 busy_ff,  busy_in;
   logic                 sign_ff,  sign_in;
   logic [IDX_BITS-1:0]  idx_ff,   idx_in;
   sida_bcd_type         bcd_ff,   bcd_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CHAR_BITS-1:0] rsp_char_ff,  rsp_char_in;
   logic                 rsp_last_ff,  rsp_last_in;
   logic                 out_load;
   logic                 finishing;
   logic                 take;
   logic [CHAR_BITS-1:0] cur_char;
   logic                 cur_last;

   // The output register loads when empty or when its item is taken.
   assign out_load  = !rsp_valid_ff || !rsp_stall;
   assign finishing = busy_ff && !sign_ff && (idx_ff == '0);
   assign in_stall  = busy_ff && !(out_load && finishing);
   assign take      = in_valid && !in_stall;

   // Character for the current position: sign first, then digits from the top.
   assign cur_char = sign_ff ? CHAR_MINUS
                             : CHAR_ZERO + {{(CHAR_BITS-4){1'b0}}, bcd_ff[idx_ff]};
   assign cur_last = !sign_ff && (idx_ff == '0);

   // Sequencer and output register next values.
   always_comb begin
      busy_in      = busy_ff;
      sign_in      = sign_ff;
      idx_in       = idx_ff;
      bcd_in       = bcd_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      if (out_load) begin
         rsp_valid_in = busy_ff;
         rsp_char_in  = cur_char;
         rsp_last_in  = cur_last;
         if (busy_ff) begin
            if (sign_ff) begin
               sign_in = 1'b0;
            end else if (idx_ff == '0) begin
               busy_in = 1'b0;
            end else begin
               idx_in = idx_ff - 1'b1;
            end
         end
      end
      if (take) begin
         busy_in = 1'b1;
         sign_in = in_data.neg;
         idx_in  = in_data.top_idx;
         bcd_in  = in_data.bcd;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      sign_ff     <= sign_in;
      idx_ff      <= idx_in;
      bcd_ff      <= bcd_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_text_char = rsp_char_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

>>> rtl/signed_int_to_decimal_ascii_top.sv
// Top level of the signed integer to decimal ASCII converter.
// Path of an item: sign register, BCD stages, digit-count register, character sequencer, output register.
// Throughput: one character per cycle while rsp_stall is low; an item has 1 to 11 characters,
// all emitted by the single character sequencer at the end of the pipeline.
// The sign, BCD and digit-count stages take an item every cycle until all six hold one.
// Reset is synchronous and active high; it empties every stage and drops all pending items.
module signed_int_to_decimal_ascii_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [sida_pkg::IN_BITS-1:0] req_value,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [sida_pkg::CHAR_BITS-1:0]    rsp_text_char,
   output logic                              rsp_last
);
   import sida_pkg::*;

   logic                  work_valid [DD_STAGES+1];
   sida_work_type         work_data  [DD_STAGES+1];
   logic                  work_stall [DD_STAGES+1];

   logic [VALUE_BITS-1:0] raw;
   logic [VALUE_BITS-1:0] mag;
   logic                  sign_advance;
   logic                  sign_valid_ff;
   sida_work_type         sign_data_ff;

   logic                  cnt_advance;
   logic                  cnt_stall;
   logic                  cnt_valid_ff;
   sida_text_type         cnt_data_ff;
   sida_text_type         cnt_data_in;

   // Sign and magnitude; the most negative value negates to itself, its exact magnitude.
   assign raw = VALUE_BITS'(req_value);
   assign mag = raw[VALUE_BITS-1] ? (~raw + 1'b1) : raw;

   assign sign_advance = !sign_valid_ff || !work_stall[0];
   assign req_stall    = !sign_advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         sign_valid_ff <= 1'b0;
      end else if (sign_advance) begin
         sign_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (sign_advance) begin
         sign_data_ff.neg <= raw[VALUE_BITS-1];
         sign_data_ff.bcd <= '0;
         sign_data_ff.bin <= PAD_BITS'(mag);
      end
   end

   assign work_valid[0] = sign_valid_ff;
   assign work_data[0]  = sign_data_ff;

   // Binary to BCD stages.
   for (genvar k = 0; k < DD_STAGES; k++) begin : g_dabble
      sida_dabble_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (work_valid[k]),
         .in_data   (work_data[k]),
         .in_stall  (work_stall[k]),
         .out_valid (work_valid[k+1]),
         .out_data  (work_data[k+1]),
         .out_stall (work_stall[k+1])
      );
   end

   // Digit count: position of the highest nonzero digit, zero for the value zero.
   assign cnt_advance           = !cnt_valid_ff || !cnt_stall;
   assign work_stall[DD_STAGES] = !cnt_advance;

   always_comb begin
      cnt_data_in.neg     = work_data[DD_STAGES].neg;
      cnt_data_in.bcd     = work_data[DD_STAGES].bcd;
      cnt_data_in.top_idx = '0;
      for (int d = 1; d < DIGITS; d++) begin
         if (work_data[DD_STAGES].bcd[d] != 4'd0) begin
            cnt_data_in.top_idx = IDX_BITS'(d);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_valid_ff <= 1'b0;
      end else if (cnt_advance) begin
         cnt_valid_ff <= work_valid[DD_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (cnt_advance) begin
         cnt_data_ff <= cnt_data_in;
      end
   end

   // Character output.
   sida_serializer u_serializer (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (cnt_valid_ff),
      .in_data       (cnt_data_ff),
      .in_stall      (cnt_stall),
      .rsp_valid     (rsp_valid),
      .rsp_text_char (rsp_text_char),
      .rsp_stall     (rsp_stall),
      .rsp_last      (rsp_last)
   );

endmodule

>>> rtl/sida_checker.sv
// Port-level checker for the decimal text converter and its bind to the top level.
`include "signed_int_to_decimal_ascii_top_macros.svh"

module sida_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic [sida_pkg::CHAR_BITS-1:0] rsp_text_char,
   input logic                           rsp_last
);
   import sida_pkg::*;

   logic               rsp_take;
   logic               rsp_wait;
   logic               is_minus;
   logic               is_digit;
   logic               lead_digit;
   logic [CHAR_BITS:0] rsp_word;

   // Handshake and character classes seen on the result port.
   assign rsp_take   = rsp_valid && !rsp_stall;
   assign rsp_wait   = rsp_valid && rsp_stall;
   assign is_minus   = (rsp_text_char == CHAR_MINUS);
   assign is_digit   = (rsp_text_char >= CHAR_ZERO) && (rsp_text_char <= CHAR_NINE);
   assign lead_digit = is_digit && (rsp_text_char != CHAR_ZERO);
   assign rsp_word   = {rsp_text_char, rsp_last};

   // A stalled item stays on the result port unchanged.
   `SIDA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_wait, rsp_valid && $stable(rsp_word), "held item changed")

   // Only the minus sign and decimal digits appear.
   `SIDA_ASSERT_NOW(a_char_legal, clock, reset, rsp_valid, is_minus || is_digit, "illegal character")

   // The sign never ends a number.
   `SIDA_ASSERT_NOW(a_minus_not_last, clock, reset, rsp_valid && is_minus, !rsp_last, "sign marked last")

   // A taken sign is followed at once by a nonzero leading digit.
   `SIDA_ASSERT_NEXT(a_minus_then_digit, clock, reset, rsp_take && is_minus, rsp_valid && lead_digit, "no digit after sign")

endmodule

bind signed_int_to_decimal_ascii_top sida_checker u_sida_checker (.*);

>>> verif/tb.sv
// Self-checking testbench for the signed integer to decimal ASCII converter.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sida_pkg::*;

   // One expected character of the decimal text.
   typedef struct packed {
      logic [CHAR_BITS-1:0] text_char;
      logic                 last;
   } decimal_char_type;

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   logic signed [IN_BITS-1:0]  req_value;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic [CHAR_BITS-1:0]       rsp_text_char;
   logic                       rsp_last;

   // Characters still owed by the block, oldest first.
   decimal_char_type pending_chars[$];
   decimal_char_type want_char;

   // When low, neither side inserts gaps or stalls.
   bit idle_on = 1'b1;

   int mismatch_count = 0;
   int items_sent     = 0;
   int negatives_sent = 0;
   int chars_checked  = 0;

   signed_int_to_decimal_ascii_top u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_text_char (rsp_text_char),
      .rsp_last      (rsp_last)
   );

   always #2 clock = ~clock;

   // Print one line for a mismatch and count it.
   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("%0t ns: mismatch: %s", $time, what);
   endtask

   // Work out the decimal text of one value and queue its characters.
   function automatic void predict_decimal_text(input logic [IN_BITS-1:0] value);
      logic [VALUE_BITS-1:0] raw;
      logic                  negative;
      logic [VALUE_BITS:0]   magnitude;
      logic [3:0]            digits[$];
      decimal_char_type      item;
      raw = value[VALUE_BITS-1:0];
      negative = raw[VALUE_BITS-1];
      // One bit wider, so the most negative value keeps its exact magnitude.
      magnitude = negative ? ({1'b0, ~raw} + 1'b1) : {1'b0, raw};
      do begin
         digits.push_back(4'(magnitude % 10));
         magnitude = magnitude / 10;
      end while (magnitude != 0);
      if (negative) begin
         item.text_char = CHAR_MINUS;
         item.last = 1'b0;
         pending_chars.push_back(item);
      end
      // Most significant digit was found last.
      while (digits.size() > 0) begin
         item.text_char = CHAR_ZERO + CHAR_BITS'(digits.pop_back());
         item.last = (digits.size() == 0);
         pending_chars.push_back(item);
      end
   endfunction

   // Offer one item, hold it until accepted, then record what it should produce.
   task automatic send_value(input logic [IN_BITS-1:0] value);
      while (idle_on && $urandom_range(99) < 16) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= value;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      predict_decimal_text(value);
      items_sent++;
      if (value[VALUE_BITS-1]) begin
         negatives_sent++;
      end
   endtask

   // Stop sending and wait until every expected character has come back.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_chars.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // Random value with a spread of text lengths and both signs.
   function automatic logic [IN_BITS-1:0] pick_value();
      logic [IN_BITS-1:0] value;
      int                 power;
      power = 1;
      case ($urandom_range(5))
         0, 1: value = $urandom;
         2: value = $urandom_range(99);
         3: begin
            repeat ($urandom_range(9)) power = power * 10;
            value = power + $urandom_range(2) - 1;
         end
         4: value = $urandom >> $urandom_range(31);
         default: begin
            case ($urandom_range(3))
               0: value = '0;
               1: value = '1;
               2: value = 32'h8000_0000;
               default: value = 32'h7FFF_FFFF;
            endcase
         end
      endcase
      if (value != 32'h8000_0000 && $urandom_range(1) == 1) begin
         value = -value;
      end
      return value;
   endfunction

   // Extremes, zero, single digits and the 1/2, 2/3 and 9/10 digit-count boundaries.
   task automatic test_directed();
      send_value(0);
      send_value(1);
      send_value(-1);
      send_value(9);
      send_value(-9);
      send_value(10);
      send_value(-10);
      send_value(99);
      send_value(100);
      send_value(32'h7FFF_FFFF);
      send_value(32'h8000_0000);
      send_value(32'h8000_0001);
      send_value(999_999_999);
      send_value(1_000_000_000);
      send_value(-999_999_999);
      send_value(-1_000_000_000);
      send_value(1_234_567_890);
      send_value(-1_234_567_890);
      send_value(32'h5555_5555);
      send_value(32'hAAAA_AAAA);
      send_value(7);
      send_value(0);
   endtask

   // Let the pipeline empty completely in the middle of a stream.
   task automatic test_drain_pause();
      repeat (5) send_value(pick_value());
      wait_drained();
      @(posedge clock);
      repeat (5) send_value(pick_value());
   endtask

   // Random values: a back-to-back stretch first, then with gaps and stalls.
   task automatic test_random_values();
      idle_on = 1'b0;
      repeat (50) send_value(pick_value());
      idle_on = 1'b1;
      repeat (78) send_value(pick_value());
   endtask

   // The receiving side stalls at random while idling is on.
   always @(posedge clock) begin
      rsp_stall <= idle_on && ($urandom_range(99) < 16);
   end

   // Compare each accepted character with the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_chars.size() == 0) begin
            report_mismatch($sformatf("unexpected character %0d", rsp_text_char));
         end else begin
            want_char = pending_chars.pop_front();
            chars_checked++;
            if (rsp_text_char !== want_char.text_char) begin
               report_mismatch($sformatf("text_char %0d, expected %0d",
                                         rsp_text_char, want_char.text_char));
            end
            if (rsp_last !== want_char.last) begin
               report_mismatch($sformatf("last %0b, expected %0b",
                                         rsp_last, want_char.last));
            end
         end
      end
   end

   // Main sequence.
   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_value = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_drain_pause();
      test_random_values();
      wait_drained();
      repeat (20) @(posedge clock);
      $display("Converted %0d values (%0d negative) and checked %0d characters,",
               items_sent, negatives_sent, chars_checked);
      $display("including both extremes, digit-count boundaries and a full drain pause.");
      if (mismatch_count == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

   // Safety limit on the whole run.
   initial begin
      #400_000;
      $display("tb failed");
      $finish;
   end
endmodule

>>> filelist.f
+incdir+rtl
rtl/sida_pkg.sv
rtl/sida_dabble_stage.sv
rtl/sida_serializer.sv
rtl/signed_int_to_decimal_ascii_top.sv
rtl/sida_checker.sv
verif/tb.sv
